### rtl/core/particle_multinomial_resampler_assert.svh
// assertion macros for the multinomial resampler
`ifndef PARTICLE_MULTINOMIAL_RESAMPLER_ASSERT_SVH
`define PARTICLE_MULTINOMIAL_RESAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmr assertion failed");

// next-cycle implication
`define PMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmr assertion failed");

`else

`define PMR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/pmr_pkg.sv
// types and constants shared by the multinomial resampler
package pmr_pkg;

    localparam int W_POS    = 32;
    localparam int W_HEAD   = 16;
    localparam int W_WEIGHT = 32;
    localparam int W_DRAW   = 32;
    localparam int W_CUM    = 40;
    localparam int W_INDEX  = 7;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef logic [W_INDEX-1:0] t_index;

    typedef struct packed {
        logic [W_CUM-1:0]         cum;
        logic signed [W_POS-1:0]  x;
        logic signed [W_POS-1:0]  y;
        logic signed [W_HEAD-1:0] h;
    } t_entry;

    typedef struct packed {
        logic load;       // store the accepted particle
        logic take_draw;  // latch the accepted draw fraction
        logic mul_lo;     // low partial product of the seed
        logic mul_hi;     // high partial product of the seed
        logic seed;       // sum partial products, rewind the scan
        logic scan;       // step the cumulative weight scan
        logic deliver;    // move the result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic hit;        // scanned entry beats the seed
        logic miss;       // scan ran out of loaded particles
        logic out_free;   // output register can take a result
    } t_dp_stat;

endpackage

### rtl/core/pmr_in_if.sv
// input channel of the multinomial resampler
interface pmr_in_if;
    import pmr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic                     first_particle;
    logic signed [W_POS-1:0]  pose_x;
    logic signed [W_POS-1:0]  pose_y;
    logic signed [W_HEAD-1:0] heading;
    logic [W_WEIGHT-1:0]      weight;
    logic [W_DRAW-1:0]        draw;

    modport source (
        output valid, req_type, first_particle, pose_x, pose_y, heading, weight, draw,
        input  ready
    );

    modport sink (
        input  valid, req_type, first_particle, pose_x, pose_y, heading, weight, draw,
        output ready
    );
endinterface

### rtl/core/pmr_out_if.sv
// result channel of the multinomial resampler
interface pmr_out_if;
    import pmr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [W_INDEX-1:0]       chosen_index;
    logic signed [W_POS-1:0]  out_x;
    logic signed [W_POS-1:0]  out_y;
    logic signed [W_HEAD-1:0] out_heading;

    modport source (
        output valid, found, chosen_index, out_x, out_y, out_heading,
        input  ready
    );

    modport sink (
        input  valid, found, chosen_index, out_x, out_y, out_heading,
        output ready
    );
endinterface

### rtl/core/pmr_datapath.sv
// particle store, seed multiplier, scan and output register
`include "particle_multinomial_resampler_assert.svh"

module pmr_datapath import pmr_pkg::*; #(
    parameter int PARTICLES = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_first_particle,
    input  logic signed [W_POS-1:0]  i_pose_x,
    input  logic signed [W_POS-1:0]  i_pose_y,
    input  logic signed [W_HEAD-1:0] i_heading,
    input  logic [W_WEIGHT-1:0]      i_weight,
    input  logic [W_DRAW-1:0]        i_draw,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_found,
    output logic [W_INDEX-1:0]       o_chosen_index,
    output logic signed [W_POS-1:0]  o_out_x,
    output logic signed [W_POS-1:0]  o_out_y,
    output logic signed [W_HEAD-1:0] o_out_heading
);

    localparam int IW = $clog2(PARTICLES);
    localparam int CW = $clog2(PARTICLES + 1);
    localparam logic [CW-1:0] FULL = CW'(PARTICLES);

    // particle store
    t_entry r_mem [PARTICLES];
    t_entry r_rd_data;

    // load side
    logic [CW-1:0]    r_count, n_count;
    logic [W_CUM-1:0] r_total, n_total;
    logic [W_CUM-1:0] base_total;
    logic [W_CUM:0]   sum_total;
    logic [CW-1:0]    base_count;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;

    // seed
    logic [W_DRAW-1:0] r_draw;
    logic [W_DRAW-1:0] r_plo_hi;
    logic [W_CUM-1:0]  r_phi;
    logic [W_CUM-1:0]  r_seed;
    logic [2*W_DRAW-1:0] plo;

    // scan
    logic [CW-1:0] r_addr;
    logic          r_dv;
    logic [IW-1:0] r_didx;
    logic          more;

    // result and output
    logic               r_res_found;
    t_index             r_res_index;
    t_entry             r_res_entry;
    logic               r_out_vld;
    logic               r_out_found;
    t_index             r_out_index;
    t_entry             r_out_entry;

    // load: restart, saturating running sum, store at the fill count
    always_comb begin
        base_total = i_first_particle ? '0 : r_total;
        base_count = i_first_particle ? '0 : r_count;
        sum_total  = {1'b0, base_total} + (W_CUM+1)'(i_weight);
        wr_en      = i_cmd.load && (base_count < FULL);
        wr_addr    = base_count[IW-1:0];
        n_total    = r_total;
        n_count    = r_count;
        if (wr_en) begin
            n_total = sum_total[W_CUM] ? '1 : sum_total[W_CUM-1:0];
            n_count = base_count + CW'(1);
        end else if (i_cmd.load) begin
            n_total = base_total;
            n_count = base_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{cum: n_total, x: i_pose_x, y: i_pose_y, h: i_heading};
        end
        r_rd_data <= r_mem[r_addr[IW-1:0]];
    end

    // seed = floor(total * draw / 2^32), two partial products
    assign plo = (2*W_DRAW)'(r_total[W_DRAW-1:0]) * (2*W_DRAW)'(r_draw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_draw) begin
            r_draw <= i_draw;
        end
        if (i_cmd.mul_lo) begin
            r_plo_hi <= plo[2*W_DRAW-1:W_DRAW];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= W_CUM'(r_total[W_CUM-1:W_DRAW]) * W_CUM'(r_draw);
        end
        if (i_cmd.seed) begin
            r_seed <= r_phi + W_CUM'(r_plo_hi);
        end
    end

    // scan: address issued one cycle, compared the next
    assign more          = r_addr < r_count;
    assign o_stat.hit    = i_cmd.scan && r_dv && (r_rd_data.cum > r_seed);
    assign o_stat.miss   = i_cmd.scan && !r_dv && !more;
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_dv   <= 1'b0;
        end else if (i_cmd.seed) begin
            r_addr <= '0;
            r_dv   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_addr <= more ? r_addr + CW'(1) : r_addr;
            r_dv   <= more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_didx <= r_addr[IW-1:0];
        end
        if (o_stat.hit) begin
            r_res_found <= 1'b1;
            r_res_index <= t_index'(r_didx);
            r_res_entry <= r_rd_data;
        end else if (o_stat.miss) begin
            r_res_found <= 1'b0;
            r_res_index <= '0;
            r_res_entry <= '0;
        end
        if (i_cmd.deliver) begin
            r_out_found <= r_res_found;
            r_out_index <= r_res_index;
            r_out_entry <= r_res_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_found        = r_out_found;
    assign o_chosen_index = r_out_index;
    assign o_out_x        = r_out_entry.x;
    assign o_out_y        = r_out_entry.y;
    assign o_out_heading  = r_out_entry.h;

    `PMR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `PMR_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, i_cmd.scan, r_addr <= r_count)
    `PMR_ASSERT_NOW(a_dv_loaded, i_clk, i_rst_n, r_dv && i_cmd.scan, CW'(r_didx) < r_count)
    `PMR_ASSERT_NOW(a_hit_xor_miss, i_clk, i_rst_n, o_stat.hit, !o_stat.miss)

endmodule

### rtl/core/pmr_ctrl.sv
// controller state machine of the multinomial resampler
`include "particle_multinomial_resampler_assert.svh"

module pmr_ctrl import pmr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_req_type,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MLO  = 6'b000010,
        S_MHI  = 6'b000100,
        S_SEED = 6'b001000,
        S_SCAN = 6'b010000,
        S_DLV  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_req_type == REQ_DRAW) begin
                        o_cmd.take_draw = 1'b1;
                        n_state         = S_MLO;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SEED;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.miss) begin
                    n_state = S_DLV;
                end
            end
            S_DLV: begin
                if (i_stat.out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PMR_ASSERT_NOW(a_no_scan_when_ready, i_clk, i_rst_n, o_in_ready, !o_cmd.scan)
    `PMR_ASSERT_NOW(a_deliver_free, i_clk, i_rst_n, o_cmd.deliver, i_stat.out_free)
    `PMR_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n,
        o_cmd.scan && (i_stat.hit || i_stat.miss), r_state == S_DLV)
    `PMR_ASSERT_NEXT(a_draw_starts_seed, i_clk, i_rst_n, o_cmd.take_draw, !o_in_ready)

endmodule

### rtl/core/particle_multinomial_resampler.sv
// Multinomial resampler for a particle filter. A load item (req_type 0) stores one particle
// pose at the fill position and its saturating running weight sum; first_particle
// restarts the fill and the sum, and loads beyond PARTICLES are dropped. A draw item
// (req_type 1) yields one result: the seed floor(total * draw / 2^32) is formed from two
// partial products in states S_MLO, S_MHI and S_SEED, then the stored cumulative weights
// are scanned one per cycle through the store's registered read port until the first one
// above the seed. found is 0 with zero pose and index when nothing qualifies. A finished
// result waits in an output register while new items are taken.
module particle_multinomial_resampler import pmr_pkg::*; #(
    parameter int PARTICLES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmr_in_if.sink    i_in,
    pmr_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmr_datapath #(
        .PARTICLES (PARTICLES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_first_particle (i_in.first_particle),
        .i_pose_x         (i_in.pose_x),
        .i_pose_y         (i_in.pose_y),
        .i_heading        (i_in.heading),
        .i_weight         (i_in.weight),
        .i_draw           (i_in.draw),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_found          (o_out.found),
        .o_chosen_index   (o_out.chosen_index),
        .o_out_x          (o_out.out_x),
        .o_out_y          (o_out.out_y),
        .o_out_heading    (o_out.out_heading)
    );

endmodule

### tb/tb_particle_multinomial_resampler.sv
// self-checking testbench for the multinomial resampler: directed and random loads and draws
module tb_particle_multinomial_resampler;
    import pmr_pkg::*;

    localparam int N_SLOTS      = 128;
    localparam int HEAD_MAX     = 25736;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    typedef enum int {MIX_SPREAD, MIX_TINY, MIX_SPARSE, MIX_HEAVY} t_weight_mix;

    typedef struct {
        logic                     kind;
        logic                     first;
        logic signed [W_POS-1:0]  x;
        logic signed [W_POS-1:0]  y;
        logic signed [W_HEAD-1:0] h;
        logic [W_WEIGHT-1:0]      w;
        logic [W_DRAW-1:0]        d;
    } t_particle_req;

    typedef struct packed {
        logic                     found;
        t_index                   idx;
        logic signed [W_POS-1:0]  x;
        logic signed [W_POS-1:0]  y;
        logic signed [W_HEAD-1:0] h;
    } t_resample_pick;

    class resample_scoreboard;
        logic [W_CUM-1:0]         cum_w [N_SLOTS];
        logic signed [W_POS-1:0]  px [N_SLOTS];
        logic signed [W_POS-1:0]  py [N_SLOTS];
        logic signed [W_HEAD-1:0] ph [N_SLOTS];
        int unsigned              n_loaded = 0;
        logic [W_CUM-1:0]         total = '0;
        t_resample_pick           picks_due [$];
        int                       mismatches = 0;
        int                       n_loads = 0;
        int                       n_draws = 0;
        int                       n_hits = 0;
        int                       n_misses = 0;

        function void note_input(t_particle_req r);
            logic [W_CUM:0]             sum;
            logic [W_CUM+W_DRAW-1:0]    prod;
            logic [W_CUM-1:0]           seed;
            t_resample_pick             p;
            bit                         hit;
            if (r.kind == REQ_LOAD) begin
                n_loads++;
                if (r.first) begin
                    n_loaded = 0;
                    total = '0;
                end
                if (n_loaded < N_SLOTS) begin
                    sum = {1'b0, total} + r.w;
                    // running sum sticks at all ones
                    if (sum[W_CUM])
                        sum = {1'b0, {W_CUM{1'b1}}};
                    total = sum[W_CUM-1:0];
                    cum_w[n_loaded] = total;
                    px[n_loaded] = r.x;
                    py[n_loaded] = r.y;
                    ph[n_loaded] = r.h;
                    n_loaded++;
                end
            end else begin
                n_draws++;
                prod = total * r.d;
                seed = prod[W_CUM+W_DRAW-1:W_DRAW];
                p = '0;
                hit = 1'b0;
                for (int i = 0; i < n_loaded && !hit; i++) begin
                    if (cum_w[i] > seed) begin
                        hit = 1'b1;
                        p.found = 1'b1;
                        p.idx = t_index'(i);
                        p.x = px[i];
                        p.y = py[i];
                        p.h = ph[i];
                    end
                end
                if (hit)
                    n_hits++;
                else
                    n_misses++;
                picks_due.insert(picks_due.size(), p);
            end
        endfunction

        function void check_result(t_resample_pick got);
            t_resample_pick want;
            if (picks_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: result with none expected: found=%0b idx=%0d x=%h y=%h h=%h",
                             got.found, got.idx, got.x, got.y, got.h);
                return;
            end
            want = picks_due.pop_front();
            if (got.found !== want.found || got.idx !== want.idx || got.x !== want.x ||
                got.y !== want.y || got.h !== want.h) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $write("mismatch: want found=%0b idx=%0d x=%h y=%h h=%h, ",
                           want.found, want.idx, want.x, want.y, want.h);
                    $display("got found=%0b idx=%0d x=%h y=%h h=%h",
                             got.found, got.idx, got.x, got.y, got.h);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pmr_in_if  in_ch ();
    pmr_out_if out_ch ();

    particle_multinomial_resampler #(.PARTICLES(N_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    resample_scoreboard sb = new;
    bit calm = 1'b0;
    bit hold_pending = 1'b0;
    int holds_done = 0;
    int cycles = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.picks_due.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [W_HEAD-1:0] rand_heading();
        return W_HEAD'(int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX);
    endfunction

    function automatic logic [W_WEIGHT-1:0] pick_weight(t_weight_mix mix);
        case (mix)
            MIX_SPREAD: return $urandom;
            MIX_TINY:   return $urandom_range(0, 15);
            MIX_SPARSE: return ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
            default:    return 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [W_DRAW-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // offer one item, after a random gap unless calm, and wait for the handshake
    task automatic send_item(t_particle_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.req_type       <= r.kind;
        in_ch.first_particle <= r.first;
        in_ch.pose_x         <= r.x;
        in_ch.pose_y         <= r.y;
        in_ch.heading        <= r.h;
        in_ch.weight         <= r.w;
        in_ch.draw           <= r.d;
        in_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_input(r);
    endtask

    task automatic send_load(logic first, logic signed [W_POS-1:0] x, logic signed [W_POS-1:0] y,
                             logic signed [W_HEAD-1:0] h, logic [W_WEIGHT-1:0] w);
        t_particle_req r;
        r.kind = REQ_LOAD;
        r.first = first;
        r.x = x;
        r.y = y;
        r.h = h;
        r.w = w;
        r.d = $urandom;
        send_item(r);
    endtask

    task automatic send_draw(logic first, logic [W_DRAW-1:0] d);
        t_particle_req r;
        r.kind = REQ_DRAW;
        r.first = first;
        r.x = $urandom;
        r.y = $urandom;
        r.h = rand_heading();
        r.w = $urandom;
        r.d = d;
        send_item(r);
    endtask

    // result side: random stalls per item unless calm, one long hold when asked
    initial begin : result_sink
        int stall;
        t_resample_pick got;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        out_ch.ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got.found = out_ch.found;
            got.idx = out_ch.chosen_index;
            got.x = out_ch.out_x;
            got.y = out_ch.out_y;
            got.h = out_ch.out_heading;
            sb.check_result(got);
            if (hold_pending) begin
                hold_pending = 1'b0;
                holds_done++;
                stall = HOLD_CYCLES;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int          counted;
        int          set_no;
        int          set_len;
        int          n_pulls;
        int          full_sets;
        logic        first;
        t_weight_mix mix;

        counted = 0;
        set_no = 0;
        full_sets = 0;
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.req_type       <= REQ_LOAD;
        in_ch.first_particle <= 1'b0;
        in_ch.pose_x         <= '0;
        in_ch.pose_y         <= '0;
        in_ch.heading        <= '0;
        in_ch.weight         <= '0;
        in_ch.draw           <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing loaded yet, first flag on a draw does nothing
        send_draw(1'b0, 32'hFFFF_FFFF);
        send_draw(1'b1, 32'h8000_0000);
        // pose and weight extremes
        send_load(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, -W_HEAD'(HEAD_MAX), 32'd0);
        send_load(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, W_HEAD'(HEAD_MAX), 32'hFFFF_FFFF);
        send_load(1'b0, $urandom, $urandom, rand_heading(), 32'd0);
        send_load(1'b0, $urandom, $urandom, rand_heading(), 32'd1);
        // zero-weight head is skipped, tie on cumulative weight must pass strictly
        send_draw(1'b0, 32'd0);
        send_draw(1'b0, 32'hFFFF_FFFF);
        send_draw(1'b1, 32'h8000_0000);
        // all weights zero: nothing qualifies
        send_load(1'b1, $urandom, $urandom, rand_heading(), 32'd0);
        send_load(1'b0, $urandom, $urandom, rand_heading(), 32'd0);
        send_draw(1'b0, $urandom);
        send_draw(1'b0, 32'hFFFF_FFFF);
        // single particle
        send_load(1'b1, $urandom, $urandom, rand_heading(), 32'hFFFF_FFFF);
        send_draw(1'b0, 32'd0);
        send_draw(1'b0, 32'hFFFF_FFFF);
        // appending without restart
        send_load(1'b0, $urandom, $urandom, rand_heading(), 32'd0);
        send_draw(1'b0, 32'hFFFF_FFFF);

        while (counted < RANDOM_ITEMS) begin
            set_no++;
            mix = t_weight_mix'($urandom_range(0, 3));
            calm = ($urandom_range(0, 3) == 0);
            if (set_no == 6) begin
                // back pressure: receiver stops while draws keep coming
                calm = 1'b1;
                hold_pending = 1'b1;
                set_len = $urandom_range(2, 6);
                n_pulls = 12;
            end else if ((set_no % 25 == 10) && full_sets < 3) begin
                full_sets++;
                set_len = N_SLOTS + $urandom_range(1, 4);
                n_pulls = $urandom_range(1, 3);
            end else begin
                set_len = $urandom_range(1, 16);
                n_pulls = $urandom_range(1, 6);
            end
            for (int i = 0; i < set_len; i++) begin
                // now and then continue the previous set instead of restarting, and rarely restart mid-set
                first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 60) == 0);
                if (first || sb.n_loaded < N_SLOTS)
                    counted++;
                send_load(first, $urandom, $urandom, rand_heading(), pick_weight(mix));
            end
            for (int i = 0; i < n_pulls; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if (sb.n_loaded < N_SLOTS)
                        counted++;
                    send_load(1'b0, $urandom, $urandom, rand_heading(), pick_weight(mix));
                end
                send_draw($urandom_range(0, 1), pick_fraction());
                counted++;
            end
        end

        // last item has been taken, stop offering it
        in_ch.valid <= 1'b0;
        calm = 1'b0;
        while (sb.picks_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d loads and %0d draws in %0d sets, %0d of them filling the store",
                 sb.n_loads, sb.n_draws, set_no, full_sets);
        $display("draws that picked a particle: %0d, draws with no pick: %0d, long holds: %0d",
                 sb.n_hits, sb.n_misses, holds_done);
        if (sb.mismatches == 0 && sb.picks_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.picks_due.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pmr_pkg.sv
rtl/core/pmr_in_if.sv
rtl/core/pmr_out_if.sv
rtl/core/pmr_datapath.sv
rtl/core/pmr_ctrl.sv
rtl/core/particle_multinomial_resampler.sv
tb/tb_particle_multinomial_resampler.sv
